FILE: hw/rtl/clkt_pkg.sv
`default_nettype none
package clkt_pkg;
  localparam int Capacity = 16;
  localparam int IdxW = $clog2(Capacity);
  localparam int LinkW = IdxW + 1;
  localparam int CntW = $clog2(Capacity + 1);
  localparam logic [LinkW-1:0] LinkNull = {LinkW{1'b1}};

  localparam logic [2:0] OpInsUnique = 3'd0;
  localparam logic [2:0] OpInsSorted = 3'd1;
  localparam logic [2:0] OpDelete    = 3'd2;
  localparam logic [2:0] OpSort      = 3'd3;
  localparam logic [2:0] OpRead      = 3'd4;

  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StUpdated  = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StDone     = 3'd3;
  localparam logic [2:0] StRecord   = 3'd4;
  localparam logic [2:0] StEmpty    = 3'd5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] id_key;
    logic [63:0] name_key;
    logic [15:0] weight_in;
    logic [19:0] price_in;
    logic [15:0] qty_in;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  deleted_count;
    logic [4:0]  entry_count;
    logic [63:0] out_id;
    logic [63:0] out_name;
    logic [15:0] out_weight;
    logic [19:0] out_price;
    logic [15:0] out_qty;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [63:0] id;
    logic [63:0] name;
    logic [15:0] weight;
    logic [19:0] price;
    logic [15:0] qty;
  } rec_t;
endpackage
`default_nettype wire

FILE: hw/rtl/clkt_if.sv
`default_nettype none
interface clkt_req_if;
  logic valid;
  logic ready;
  clkt_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clkt_rsp_if;
  logic valid;
  logic ready;
  clkt_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/clkt_store.sv
`default_nettype none
module clkt_store (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [clkt_pkg::IdxW-1:0] waddr,
  input  wire clkt_pkg::rec_t wdata,
  input  wire logic [clkt_pkg::IdxW-1:0] raddr,
  output clkt_pkg::rec_t rdata
);
  clkt_pkg::rec_t mem [clkt_pkg::Capacity];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/cursor_list_keyed_table.sv
// Unique insert, delete, read and sorted insert walk the list entry by entry;
// sort is quadratic in the number of linked entries.
// One operation at a time: req.ready is low from acceptance until its last item
// is taken; read-out issues each item only once the previous one has been taken.
// The walk is set by the single record-store read port and the shared compare.
// Reset (rst, synchronous): free list from highest slot down, list empty, count 0.
`default_nettype none
module cursor_list_keyed_table (
  input wire logic clk,
  input wire logic rst,
  clkt_req_if.sink req,
  clkt_rsp_if.source rsp
);
  localparam int IdxW = clkt_pkg::IdxW;
  localparam int LinkW = clkt_pkg::LinkW;
  localparam int CntW = clkt_pkg::CntW;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_CHK   = 9'b000000100,
    S_INS   = 9'b000001000,
    S_SRD   = 9'b000010000,
    S_SCHK  = 9'b000100000,
    S_SWP1  = 9'b001000000,
    S_SWP2  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  clkt_pkg::req_t cur;
  logic [LinkW-1:0] next_link [clkt_pkg::Capacity];
  logic [LinkW-1:0] free_head, list_head, walk, prev, step, best;
  logic [CntW-1:0] record_count, guard, guard2, removed;
  logic [63:0] best_name;
  clkt_pkg::rec_t step_rec, best_rec;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  clkt_pkg::rec_t wdata, rdata;

  logic rsp_valid;
  clkt_pkg::rsp_t rsp_data;
  logic read_mode;

  clkt_store u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic vl(input logic [LinkW-1:0] v);
    return v < LinkW'(clkt_pkg::Capacity);
  endfunction

  assign req.ready = (state == S_IDLE) && !rsp_valid;
  assign rsp.valid = rsp_valid;
  assign rsp.data = rsp_data;

  always_comb begin
    raddr = walk[IdxW-1:0];
    we = 1'b0;
    waddr = walk[IdxW-1:0];
    wdata = rdata;
    case (state)
      S_SRD: raddr = walk[IdxW-1:0];
      S_CHK: begin
        if (cur.opcode == clkt_pkg::OpInsUnique && rdata.id == cur.id_key) begin
          we = 1'b1;
          wdata.weight = cur.weight_in;
          wdata.price = cur.price_in;
          wdata.qty = ({1'b0, rdata.qty} + {1'b0, cur.qty_in}) > 17'hFFFF
                      ? 16'hFFFF : 16'(rdata.qty + cur.qty_in);
        end
      end
      S_INS: begin
        we = 1'b1;
        waddr = free_head[IdxW-1:0];
        wdata = '{id: cur.id_key, name: cur.name_key, weight: cur.weight_in,
                  price: cur.price_in, qty: cur.qty_in};
      end
      S_SWP1: begin
        we = !read_mode;
        waddr = step[IdxW-1:0];
        wdata = best_rec;
      end
      S_SWP2: begin
        we = 1'b1;
        waddr = best[IdxW-1:0];
        wdata = step_rec;
      end
      default: ;
    endcase
  end

  function automatic clkt_pkg::rsp_t mk(input logic [2:0] st, input logic [CntW-1:0] dc,
                                        input logic [CntW-1:0] ec);
    clkt_pkg::rsp_t r;
    r = '0;
    r.status = st;
    r.deleted_count = 5'(dc);
    r.entry_count = 5'(ec);
    r.last = 1'b1;
    return r;
  endfunction

  // Link patch: prev == null means list_head.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
      read_mode <= 1'b0;
      free_head <= LinkW'(clkt_pkg::Capacity - 1);
      list_head <= clkt_pkg::LinkNull;
      record_count <= '0;
      for (int i = 0; i < clkt_pkg::Capacity; i++) begin
        next_link[i] <= (i == 0) ? clkt_pkg::LinkNull : LinkW'(i - 1);
      end
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.data;
            walk <= list_head;
            prev <= clkt_pkg::LinkNull;
            guard <= '0;
            removed <= '0;
            step <= list_head;
            case (req.data.opcode)
              clkt_pkg::OpInsUnique, clkt_pkg::OpDelete, clkt_pkg::OpRead:
                state <= S_RD;
              clkt_pkg::OpInsSorted: begin
                if (record_count < CntW'(clkt_pkg::Capacity)) begin
                  state <= S_RD;
                end else begin
                  rsp_data <= mk(clkt_pkg::StFull, '0, record_count);
                  rsp_valid <= 1'b1;
                end
              end
              clkt_pkg::OpSort: state <= S_SRD;
              default: ;
            endcase
          end
        end
        S_RD: begin
          if (!vl(walk) || guard == CntW'(clkt_pkg::Capacity)) begin
            case (cur.opcode)
              clkt_pkg::OpDelete: begin
                rsp_data <= mk(clkt_pkg::StDone, removed, record_count);
                rsp_valid <= 1'b1;
                state <= S_IDLE;
              end
              clkt_pkg::OpRead: begin
                if (guard == '0) begin
                  rsp_data <= mk(clkt_pkg::StEmpty, '0, record_count);
                  rsp_valid <= 1'b1;
                end
                state <= S_IDLE;
              end
              default: begin
                if (record_count < CntW'(clkt_pkg::Capacity) && vl(free_head)) begin
                  state <= S_INS;
                end else begin
                  rsp_data <= mk(clkt_pkg::StFull, '0, record_count);
                  rsp_valid <= 1'b1;
                  state <= S_IDLE;
                end
              end
            endcase
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          case (cur.opcode)
            clkt_pkg::OpInsUnique: begin
              if (rdata.id == cur.id_key) begin
                rsp_data <= mk(clkt_pkg::StUpdated, '0, record_count);
                rsp_valid <= 1'b1;
                state <= S_IDLE;
              end else begin
                prev <= walk;
                walk <= next_link[walk[IdxW-1:0]];
                guard <= guard + 1'b1;
                state <= S_RD;
              end
            end
            clkt_pkg::OpInsSorted: begin
              if (!(rdata.name < cur.name_key)) begin
                state <= vl(free_head) ? S_INS : S_IDLE;
                if (!vl(free_head)) begin
                  rsp_data <= mk(clkt_pkg::StFull, '0, record_count);
                  rsp_valid <= 1'b1;
                end
              end else begin
                prev <= walk;
                walk <= next_link[walk[IdxW-1:0]];
                guard <= guard + 1'b1;
                state <= S_RD;
              end
            end
            clkt_pkg::OpDelete: begin
              guard <= guard + 1'b1;
              walk <= next_link[walk[IdxW-1:0]];
              if (rdata.name == cur.name_key) begin
                if (vl(prev)) next_link[prev[IdxW-1:0]] <= next_link[walk[IdxW-1:0]];
                else list_head <= next_link[walk[IdxW-1:0]];
                next_link[walk[IdxW-1:0]] <= free_head;
                free_head <= walk;
                if (record_count != '0) record_count <= record_count - 1'b1;
                removed <= removed + 1'b1;
              end else begin
                prev <= walk;
              end
              state <= S_RD;
            end
            default: begin
              // read out: hold until previous item taken
              if (!rsp_valid || rsp.ready) begin
                rsp_data <= '{status: clkt_pkg::StRecord, deleted_count: 5'd0,
                              entry_count: 5'(record_count), out_id: rdata.id,
                              out_name: rdata.name, out_weight: rdata.weight,
                              out_price: rdata.price, out_qty: rdata.qty,
                              last: !vl(next_link[walk[IdxW-1:0]]) ||
                                    guard == CntW'(clkt_pkg::Capacity - 1)};
                rsp_valid <= 1'b1;
                walk <= next_link[walk[IdxW-1:0]];
                guard <= guard + 1'b1;
                state <= S_RD;
              end
            end
          endcase
        end
        S_INS: begin
          free_head <= next_link[free_head[IdxW-1:0]];
          next_link[free_head[IdxW-1:0]] <=
            (cur.opcode == clkt_pkg::OpInsSorted && vl(walk)) ? walk : clkt_pkg::LinkNull;
          if (vl(prev)) next_link[prev[IdxW-1:0]] <= free_head;
          else list_head <= free_head;
          record_count <= record_count + 1'b1;
          rsp_data <= mk(clkt_pkg::StInserted, '0, record_count + 1'b1);
          rsp_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_SRD: begin
          // outer step: walk from step to find minimum name
          if (!vl(step) || guard == CntW'(clkt_pkg::Capacity)) begin
            rsp_data <= mk(clkt_pkg::StDone, '0, record_count);
            rsp_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            walk <= step;
            best <= step;
            guard2 <= '0;
            state <= S_SCHK;
            read_mode <= 1'b1;
          end
        end
        S_SCHK: begin
          if (read_mode) begin
            read_mode <= 1'b0;
          end else if (!vl(walk) || guard2 == CntW'(clkt_pkg::Capacity)) begin
            walk <= step;
            state <= S_SWP1;
            read_mode <= 1'b1;
          end else begin
            if (walk == step || rdata.name < best_name) begin
              best <= walk;
              best_name <= rdata.name;
              best_rec <= rdata;
            end
            walk <= next_link[walk[IdxW-1:0]];
            guard2 <= guard2 + 1'b1;
            read_mode <= 1'b1;
          end
        end
        S_SWP1: begin
          // wait for step record, then write best into step
          if (read_mode) begin
            read_mode <= 1'b0;
          end else if (best == step) begin
            step <= next_link[step[IdxW-1:0]];
            guard <= guard + 1'b1;
            state <= S_SRD;
          end else begin
            step_rec <= rdata;
            state <= S_SWP2;
          end
        end
        S_SWP2: begin
          step <= next_link[step[IdxW-1:0]];
          guard <= guard + 1'b1;
          state <= S_SRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // S_SWP1 writes only once read_mode has cleared, after the step record has been read.

  assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.data.opcode <= clkt_pkg::OpRead |=> !req.ready)
    else $error("accepted while busy");
  assert property (@(posedge clk) disable iff (rst) record_count <= CntW'(clkt_pkg::Capacity))
    else $error("count overflow");
  assert property (@(posedge clk) disable iff (rst) state == S_INS |-> vl(free_head))
    else $error("insert without free slot");
endmodule
`default_nettype wire

FILE: sim/cursor_list_keyed_table_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module cursor_list_keyed_table_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire clkt_pkg::req_t req_data,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire clkt_pkg::rsp_t rsp_data,
  output int fail_count,
  output int pending
);
  clkt_pkg::rec_t slot_rec [clkt_pkg::Capacity];
  int link_of [clkt_pkg::Capacity];
  int free_top;
  int head;
  int count;
  clkt_pkg::rsp_t expected_rsps [$];

  function automatic clkt_pkg::rsp_t status_only(logic [2:0] st, int removed);
    clkt_pkg::rsp_t r;
    r = '0;
    r.status = st;
    r.deleted_count = removed[4:0];
    r.entry_count = count[4:0];
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int grab_slot();
    int s;
    s = free_top;
    if (s >= 0) free_top = link_of[s];
    return s;
  endfunction

  task automatic apply_op(clkt_pkg::req_t q);
    int cur, prv, s, best, scan, n, removed, nxt;
    logic [16:0] sum;
    clkt_pkg::rec_t tmp;
    clkt_pkg::rsp_t r;
    case (q.opcode)
      clkt_pkg::OpInsUnique: begin
        cur = head;
        prv = -1;
        while (cur >= 0 && slot_rec[cur].id != q.id_key) begin
          prv = cur;
          cur = link_of[cur];
        end
        if (cur >= 0) begin
          slot_rec[cur].weight = q.weight_in;
          slot_rec[cur].price = q.price_in;
          sum = {1'b0, slot_rec[cur].qty} + {1'b0, q.qty_in};
          slot_rec[cur].qty = sum[16] ? 16'hFFFF : sum[15:0];
          expected_rsps.push_back(status_only(clkt_pkg::StUpdated, 0));
        end else if (count < clkt_pkg::Capacity) begin
          s = grab_slot();
          slot_rec[s] = '{q.id_key, q.name_key, q.weight_in, q.price_in, q.qty_in};
          link_of[s] = -1;
          if (prv < 0) head = s; else link_of[prv] = s;
          count++;
          expected_rsps.push_back(status_only(clkt_pkg::StInserted, 0));
        end else expected_rsps.push_back(status_only(clkt_pkg::StFull, 0));
      end
      clkt_pkg::OpInsSorted: begin
        if (count < clkt_pkg::Capacity) begin
          cur = head;
          prv = -1;
          while (cur >= 0 && slot_rec[cur].name < q.name_key) begin
            prv = cur;
            cur = link_of[cur];
          end
          s = grab_slot();
          slot_rec[s] = '{q.id_key, q.name_key, q.weight_in, q.price_in, q.qty_in};
          link_of[s] = cur;
          if (prv < 0) head = s; else link_of[prv] = s;
          count++;
          expected_rsps.push_back(status_only(clkt_pkg::StInserted, 0));
        end else expected_rsps.push_back(status_only(clkt_pkg::StFull, 0));
      end
      clkt_pkg::OpDelete: begin
        removed = 0;
        cur = head;
        prv = -1;
        while (cur >= 0) begin
          nxt = link_of[cur];
          if (slot_rec[cur].name == q.name_key) begin
            if (prv < 0) head = nxt; else link_of[prv] = nxt;
            link_of[cur] = free_top;
            free_top = cur;
            count--;
            removed++;
          end else prv = cur;
          cur = nxt;
        end
        expected_rsps.push_back(status_only(clkt_pkg::StDone, removed));
      end
      clkt_pkg::OpSort: begin
        cur = head;
        while (cur >= 0) begin
          best = cur;
          scan = cur;
          while (scan >= 0) begin
            if (slot_rec[scan].name < slot_rec[best].name) best = scan;
            scan = link_of[scan];
          end
          tmp = slot_rec[cur];
          slot_rec[cur] = slot_rec[best];
          slot_rec[best] = tmp;
          cur = link_of[cur];
        end
        expected_rsps.push_back(status_only(clkt_pkg::StDone, 0));
      end
      clkt_pkg::OpRead: begin
        if (head < 0) expected_rsps.push_back(status_only(clkt_pkg::StEmpty, 0));
        else begin
          cur = head;
          n = 0;
          while (cur >= 0 && n < clkt_pkg::Capacity) begin
            r = status_only(clkt_pkg::StRecord, 0);
            r.out_id = slot_rec[cur].id;
            r.out_name = slot_rec[cur].name;
            r.out_weight = slot_rec[cur].weight;
            r.out_price = slot_rec[cur].price;
            r.out_qty = slot_rec[cur].qty;
            r.last = (link_of[cur] < 0) || (n + 1 >= clkt_pkg::Capacity);
            expected_rsps.push_back(r);
            n++;
            cur = link_of[cur];
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    clkt_pkg::rsp_t e;
    if (rst) begin
      for (int i = 0; i < clkt_pkg::Capacity; i++) begin
        link_of[i] = i - 1;
        slot_rec[i] = '0;
      end
      free_top = clkt_pkg::Capacity - 1;
      head = -1;
      count = 0;
      fail_count = 0;
      expected_rsps.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result item, status %0d", rsp_data.status);
          fail_count++;
        end else begin
          e = expected_rsps.pop_front();
          check_field("status", e.status, rsp_data.status);
          check_field("deleted_count", e.deleted_count, rsp_data.deleted_count);
          check_field("entry_count", e.entry_count, rsp_data.entry_count);
          check_field("out_id", e.out_id, rsp_data.out_id);
          check_field("out_name", e.out_name, rsp_data.out_name);
          check_field("out_weight", e.out_weight, rsp_data.out_weight);
          check_field("out_price", e.out_price, rsp_data.out_price);
          check_field("out_qty", e.out_qty, rsp_data.out_qty);
          check_field("last", e.last, rsp_data.last);
        end
      end
      if (req_valid && req_ready) apply_op(req_data);
    end
    pending = expected_rsps.size();
  end
endmodule
`default_nettype wire

FILE: sim/cursor_list_keyed_table_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module cursor_list_keyed_table_tb;
  logic clk;
  logic rst;
  int cycle_count;
  int fail_count;
  int pending;
  int rsp_wait;

  clkt_req_if req ();
  clkt_rsp_if rsp ();

  cursor_list_keyed_table uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  cursor_list_keyed_table_checker checker_i (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // After most taken result items, draw a random stall and hold ready low while it counts down.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      rsp_wait <= 0;
    end else if (rsp_wait > 0) begin
      rsp.ready <= 1'b0;
      rsp_wait <= rsp_wait - 1;
    end else if (rsp.valid && rsp.ready) begin
      if ($urandom_range(3) == 0) begin
        rsp.ready <= 1'b1;
      end else begin
        rsp.ready <= 1'b0;
        rsp_wait <= $urandom_range(12);
      end
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Small name/ID pools make matches, duplicates and deletes frequent.
  function automatic logic [63:0] pick_key(int pool);
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return 64'h0;
      default: return 64'h4100_0000_0000_0000 + 64'($urandom_range(pool));
    endcase
  endfunction

  // Hold valid across a zero gap; drop it only when idling follows.
  task automatic send_op(logic [2:0] op, logic [63:0] idk, logic [63:0] nk,
                         logic [15:0] w, logic [19:0] p, logic [15:0] qt);
    int gap;
    req.valid <= 1'b1;
    req.data <= '{op, idk, nk, w, p, qt};
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int r;
    logic [2:0] op;
    r = $urandom_range(99);
    if (r < 35) op = clkt_pkg::OpInsUnique;
    else if (r < 60) op = clkt_pkg::OpInsSorted;
    else if (r < 75) op = clkt_pkg::OpDelete;
    else if (r < 83) op = clkt_pkg::OpSort;
    else if (r < 97) op = clkt_pkg::OpRead;
    else op = 3'($urandom_range(7, 5));
    send_op(op, pick_key(6), pick_key(5), 16'($urandom), 20'($urandom), 16'($urandom));
  endtask

  initial begin
    cycle_count = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_op(clkt_pkg::OpRead, 0, 0, 0, 0, 0);
    send_op(clkt_pkg::OpDelete, 0, 64'h4200_0000_0000_0000, 0, 0, 0);
    send_op(clkt_pkg::OpSort, 0, 0, 0, 0, 0);
    send_op(clkt_pkg::OpInsUnique, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
            16'hFFFF, 20'hFFFFF, 16'hFFF0);
    send_op(clkt_pkg::OpInsUnique, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 16'h1234, 20'h0,
            16'h00FF);
    send_op(clkt_pkg::OpInsSorted, 64'h0, 64'h0, 16'h0, 20'h0, 16'h0);
    send_op(clkt_pkg::OpInsSorted, 64'h5, 64'h0, 16'h5, 20'h5, 16'h5);
    send_op(clkt_pkg::OpInsSorted, 64'h6, 64'h8000_0000_0000_0000, 16'h6, 20'h6, 16'h6);
    send_op(clkt_pkg::OpInsUnique, 64'h7, 64'h0, 16'h7, 20'h7, 16'h7);
    send_op(3'd5, 0, 0, 0, 0, 0);
    send_op(3'd7, 64'h7, 0, 0, 0, 0);
    send_op(clkt_pkg::OpRead, 0, 0, 0, 0, 0);
    send_op(clkt_pkg::OpSort, 0, 0, 0, 0, 0);
    send_op(clkt_pkg::OpRead, 0, 0, 0, 0, 0);
    for (int i = 0; i < 14; i++)
      send_op(clkt_pkg::OpInsUnique, 64'h100 + 64'(i), 64'($urandom_range(3)),
              16'(i), 20'(i), 16'(i));
    send_op(clkt_pkg::OpInsSorted, 64'h999, 64'h3, 0, 0, 0);
    send_op(clkt_pkg::OpRead, 0, 0, 0, 0, 0);
    send_op(clkt_pkg::OpDelete, 0, 64'h0, 0, 0, 0);
    send_op(clkt_pkg::OpRead, 0, 0, 0, 0, 0);
    for (int i = 0; i < 310; i++) send_random();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
